// ----- hdl/ptrf_pkg.sv -----
// Shared constants and types of the pulse-train ring filler.
package ptrf_pkg;

  localparam int DepthDefault = 128;
  localparam int DepthMin     = 16;

  localparam int WordW  = 16;
  localparam int CountW = 16;
  localparam int SlotW  = 7;
  localparam int KindW  = 2;
  localparam int CfgIdxW = 2;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_PIN_MASK    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HIGH_RELOAD = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOW_RELOAD  = 2'd2;

  // Write index lands this many slots ahead of the reader on initialize.
  localparam int InitLead = 10;

  // Subtract steps that bring any reader index below the smallest ring.
  localparam int ModSteps = (1 << SlotW) / DepthMin;

  localparam logic [KindW-1:0] KIND_SERVICE = 2'd0;
  localparam logic [KindW-1:0] KIND_READ    = 2'd1;
  localparam logic [KindW-1:0] KIND_INIT    = 2'd2;

  typedef enum logic [2:0] {
    RING_IDLE,
    RING_READ,
    RING_SET,
    RING_CLR,
    RING_ZERO
  } ring_op_t;

endpackage

// ----- hdl/pulse_train_ring_filler.sv -----
// Top level of the pulse-train ring filler: configuration registers, sequencer and ring.
//
// The block keeps a ring of DEPTH 16-bit words that a DMA engine drains and
// fills the bits selected by pin_mask with a pulse train: a high run and then
// a low run, written only into the free slots between the write index and the
// reader. A command is transferred at a rising edge where start is high and
// busy is low; in_kind selects a service refill, a read of one ring word, or
// an initialize that sets the pin bits of every slot to in_level and puts the write index
// ten slots ahead of the reader. Every command gives exactly one result,
// shown for one cycle with out_strobe high; the receiver cannot hold it off.
// The sequencer walks the single ring memory one slot per cycle through a
// read-modify-write stage. Busy is high from transfer until the result is
// shown, so one command is in work at a time. After reset the sequencer
// clears the ring to zero in one pass with busy high; configuration writes
// through cfg_we, cfg_index and cfg_wdata are taken at any time, but are
// meant for idle time.
module pulse_train_ring_filler import ptrf_pkg::*; #(
  parameter int DEPTH = DepthDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [KindW-1:0]   in_kind,
  input  logic [SlotW-1:0]   in_reader_index,
  input  logic               in_level,
  output logic               out_strobe,
  output logic [CountW-1:0]  out_high_left,
  output logic [CountW-1:0]  out_low_left,
  output logic [SlotW-1:0]   out_write_index,
  output logic [WordW-1:0]   out_read_word,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [WordW-1:0]   cfg_wdata
);

  localparam int AW = $clog2(DEPTH);

  logic [WordW-1:0]  pin_mask_r, pin_mask_nxt;
  logic [CountW-1:0] high_reload_r, high_reload_nxt;
  logic [CountW-1:0] low_reload_r, low_reload_nxt;

  ring_op_t          ring_op;
  logic [AW-1:0]     ring_addr;
  logic [WordW-1:0]  ring_rdata;

  // Register writes; an index beyond the register list is ignored.
  always_comb begin
    pin_mask_nxt    = pin_mask_r;
    high_reload_nxt = high_reload_r;
    low_reload_nxt  = low_reload_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_PIN_MASK:    pin_mask_nxt    = cfg_wdata;
        CFG_HIGH_RELOAD: high_reload_nxt = cfg_wdata;
        CFG_LOW_RELOAD:  low_reload_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_mask_r    <= WordW'(1);
      high_reload_r <= '0;
      low_reload_r  <= '0;
    end else begin
      pin_mask_r    <= pin_mask_nxt;
      high_reload_r <= high_reload_nxt;
      low_reload_r  <= low_reload_nxt;
    end
  end

  // The sequencer issues at most one ring access per cycle and keeps the
  // write index and the remaining run counts.
  ptrf_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_reader_index (in_reader_index),
    .in_level        (in_level),
    .high_reload     (high_reload_r),
    .low_reload      (low_reload_r),
    .ring_op         (ring_op),
    .ring_addr       (ring_addr),
    .ring_rdata      (ring_rdata),
    .out_strobe      (out_strobe),
    .out_high_left   (out_high_left),
    .out_low_left    (out_low_left),
    .out_write_index (out_write_index),
    .out_read_word   (out_read_word)
  );

  // The ring sets or clears the pin bits of a slot in the cycle after reading it.
  ptrf_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (ring_op),
    .addr  (ring_addr),
    .mask  (pin_mask_r),
    .rdata (ring_rdata)
  );

endmodule

// ----- hdl/ptrf_ring.sv -----
// Ring memory with a registered read and a read-modify-write stage for pin bits.
module ptrf_ring import ptrf_pkg::*; #(
  parameter int DEPTH = DepthDefault,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ring_op_t         op,
  input  logic [AW-1:0]    addr,
  input  logic [WordW-1:0] mask,
  output logic [WordW-1:0] rdata
);

  logic [WordW-1:0] mem [DEPTH];
  logic [WordW-1:0] rdata_r;
  logic             pend_r;
  logic             pend_set_r;
  logic [AW-1:0]    pend_addr_r;

  logic             rd_en;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [WordW-1:0] wdata;

  assign rd_en = (op == RING_READ) || (op == RING_SET) || (op == RING_CLR);

  // The write-back of the previous slot never targets the slot read in the
  // same cycle, since a run walks distinct slots, so no forwarding is needed.
  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = '0;
    if (pend_r) begin
      we    = 1'b1;
      waddr = pend_addr_r;
      wdata = pend_set_r ? (rdata_r | mask) : (rdata_r & ~mask);
    end else if (op == RING_ZERO) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
    pend_addr_r <= addr;
    pend_set_r  <= (op == RING_SET);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= (op == RING_SET) || (op == RING_CLR);
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/ptrf_seq.sv -----
// Sequencer: clearing pass, service runs, initialize sweep and word reads.
module ptrf_seq import ptrf_pkg::*; #(
  parameter int DEPTH = DepthDefault,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [KindW-1:0]  in_kind,
  input  logic [SlotW-1:0]  in_reader_index,
  input  logic              in_level,
  input  logic [CountW-1:0] high_reload,
  input  logic [CountW-1:0] low_reload,
  output ring_op_t          ring_op,
  output logic [AW-1:0]     ring_addr,
  input  logic [WordW-1:0]  ring_rdata,
  output logic              out_strobe,
  output logic [CountW-1:0] out_high_left,
  output logic [CountW-1:0] out_low_left,
  output logic [SlotW-1:0]  out_write_index,
  output logic [WordW-1:0]  out_read_word
);

  localparam int MW = (AW + 1 > SlotW) ? AW + 1 : SlotW;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FREE  = 3'd2;
  localparam logic [2:0] ST_HRUN  = 3'd3;
  localparam logic [2:0] ST_LRUN  = 3'd4;
  localparam logic [2:0] ST_INIT  = 3'd5;
  localparam logic [2:0] ST_READ  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] slot_mod(input logic [SlotW-1:0] v);
    logic [MW-1:0] t;
    t = MW'(v);
    for (int i = 0; i < ModSteps; i++) begin
      if (t >= MW'(DEPTH)) begin
        t = t - MW'(DEPTH);
      end
    end
    return t[AW-1:0];
  endfunction

  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     rd_r, rd_nxt;
  logic              lvl_r, lvl_nxt;
  logic [AW-1:0]     fill_r, fill_nxt;
  logic [AW-1:0]     free_r, free_nxt;
  logic [CountW-1:0] high_r, high_nxt;
  logic [CountW-1:0] low_r, low_nxt;
  logic              strobe_r, strobe_nxt;
  logic [CountW-1:0] oh_r, oh_nxt;
  logic [CountW-1:0] ol_r, ol_nxt;
  logic [SlotW-1:0]  ow_r, ow_nxt;
  logic [WordW-1:0]  ord_r, ord_nxt;

  logic [AW-1:0] rd_mod;
  logic [AW-1:0] fill_inc;
  logic [AW:0]   free_calc;
  logic [AW:0]   lead_sum;
  logic [AW-1:0] lead_slot;
  logic          accept;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign rd_mod   = slot_mod(in_reader_index);
  assign fill_inc = (fill_r == LastSlot) ? '0 : fill_r + 1'b1;

  always_comb begin
    if (rd_r < fill_r) begin
      free_calc = (AW+1)'(DEPTH) - {1'b0, fill_r} + {1'b0, rd_r};
    end else begin
      free_calc = {1'b0, rd_r} - {1'b0, fill_r};
    end
    lead_sum  = {1'b0, rd_r} + (AW+1)'(InitLead);
    lead_slot = (lead_sum >= (AW+1)'(DEPTH)) ? AW'(lead_sum - (AW+1)'(DEPTH))
                                            : lead_sum[AW-1:0];
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    rd_nxt     = rd_r;
    lvl_nxt    = lvl_r;
    fill_nxt   = fill_r;
    free_nxt   = free_r;
    high_nxt   = high_r;
    low_nxt    = low_r;
    strobe_nxt = 1'b0;
    oh_nxt     = oh_r;
    ol_nxt     = ol_r;
    ow_nxt     = ow_r;
    ord_nxt    = ord_r;
    ring_op    = RING_IDLE;
    ring_addr  = fill_r;

    case (state_r)
      ST_CLEAR: begin
        ring_op   = RING_ZERO;
        ring_addr = idx_r;
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == LastSlot) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          rd_nxt  = rd_mod;
          lvl_nxt = in_level;
          idx_nxt = '0;
          case (in_kind)
            KIND_SERVICE: state_nxt = ST_FREE;
            KIND_READ: begin
              ring_op   = RING_READ;
              ring_addr = rd_mod;
              state_nxt = ST_READ;
            end
            KIND_INIT: state_nxt = ST_INIT;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_FREE: begin
        free_nxt = free_calc[AW-1:0];
        if (high_r != '0) begin
          low_nxt   = low_reload;
          state_nxt = ST_HRUN;
        end else begin
          state_nxt = ST_LRUN;
        end
      end
      ST_HRUN: begin
        if (high_r != '0 && free_r != '0) begin
          ring_op  = RING_SET;
          high_nxt = high_r - 1'b1;
          free_nxt = free_r - 1'b1;
          fill_nxt = fill_inc;
        end else begin
          state_nxt = (high_r == '0) ? ST_LRUN : ST_DONE;
        end
      end
      ST_LRUN: begin
        if (low_r != '0 && free_r != '0) begin
          ring_op  = RING_CLR;
          low_nxt  = low_r - 1'b1;
          free_nxt = free_r - 1'b1;
          fill_nxt = fill_inc;
        end else begin
          if (low_r == '0) begin
            high_nxt = high_reload;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_INIT: begin
        ring_op   = lvl_r ? RING_SET : RING_CLR;
        ring_addr = idx_r;
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == LastSlot) begin
          idx_nxt   = '0;
          fill_nxt  = lead_slot;
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        strobe_nxt = 1'b1;
        oh_nxt     = high_r;
        ol_nxt     = low_r;
        ow_nxt     = SlotW'(fill_r);
        ord_nxt    = ring_rdata;
        state_nxt  = ST_IDLE;
      end
      ST_DONE: begin
        strobe_nxt = 1'b1;
        oh_nxt     = high_r;
        ol_nxt     = low_r;
        ow_nxt     = SlotW'(fill_r);
        ord_nxt    = '0;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      idx_r    <= '0;
      fill_r   <= '0;
      high_r   <= '0;
      low_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      fill_r   <= fill_nxt;
      high_r   <= high_nxt;
      low_r    <= low_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r   <= rd_nxt;
    lvl_r  <= lvl_nxt;
    free_r <= free_nxt;
    oh_r   <= oh_nxt;
    ol_r   <= ol_nxt;
    ow_r   <= ow_nxt;
    ord_r  <= ord_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_high_left   = oh_r;
  assign out_low_left    = ol_r;
  assign out_write_index = ow_r;
  assign out_read_word   = ord_r;

endmodule
